/* sv/schr_pkg.sv */
// shared types, constants and binomial table for the spin chain row generator
package schr_pkg;

  localparam int MAX_SITES_DEF = 16;

  // fixed field widths
  localparam int STATE_W = 16;
  localparam int FIELD_W = 24;
  localparam int IDX_W   = 14;
  localparam int VAL_W   = 32;
  localparam int SIDX_W  = 4;
  localparam int NSITE_W = 5;

  // function codes of an input word
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STATE = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SITES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP       = 1'b1;

  localparam logic [NSITE_W-1:0] NUM_SITES_RST = 5'd16;
  localparam logic [FIELD_W-1:0] HOP_RST       = 24'd131072;

  // +1 in q16.16
  localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

  // queue between front and back
  localparam int QDEPTH = 2;

  // binomial table, values kept modulo 2^14 like the indices
  localparam int BINOM_N   = 32;
  localparam int BINOM_P_W = 5;
  localparam int BINOM_K_W = 6;

  typedef logic [BINOM_N-1:0][BINOM_N:0][IDX_W-1:0] binom_tab_t;

  typedef struct packed {
    logic               func;
    logic [SIDX_W-1:0]  site_index;
    logic [FIELD_W-1:0] field_value;
    logic [STATE_W-1:0] basis_state;
    logic [IDX_W-1:0]   col;
  } qentry_t;

  function automatic binom_tab_t binom_tab_f();
    binom_tab_t t;
    t = '0;
    for (int p = 0; p < BINOM_N; p++) begin
      t[p][0] = IDX_W'(1);
      for (int k = 1; k <= BINOM_N; k++) begin
        if (p > 0) begin
          t[p][k] = t[p-1][k] + t[p-1][k-1];
        end
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM_TAB = binom_tab_f();

  function automatic logic [IDX_W-1:0] binom_mod(input logic [BINOM_P_W-1:0] p,
                                                 input logic [BINOM_K_W-1:0] k);
    if (int'(k) > BINOM_N) begin
      return '0;
    end
    return BINOM_TAB[p][k];
  endfunction

endpackage

/* sv/schr_if.sv */
// channel interfaces: input words, result words and configuration writes
interface schr_in_if;
  import schr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [SIDX_W-1:0]         site_index;
  logic signed [FIELD_W-1:0] field_value;
  logic [STATE_W-1:0]        basis_state;
  modport source (output valid, func, site_index, field_value, basis_state, input ready);
  modport sink (input valid, func, site_index, field_value, basis_state, output ready);
endinterface

interface schr_out_if;
  import schr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] entry_value;
  logic                    last;
  modport source (output valid, row_index, col_index, entry_value, last, input ready);
  modport sink (input valid, row_index, col_index, entry_value, last, output ready);
endinterface

interface schr_cfg_if;
  import schr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/schr_queue.sv */
// short fifo carrying classified words from the front to the back
module schr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  schr_pkg::qentry_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output schr_pkg::qentry_t rd_data
);
  import schr_pkg::*;

  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  qentry_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push, pop;

  assign wr_ready = (count_r != QCNT_W'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* sv/schr_front.sv */
// front end: accepts words, masks the state and works out its colex rank
module schr_front #(
  parameter int MAX_SITES = schr_pkg::MAX_SITES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  schr_in_if.sink                        in_ch,
  input  logic [$clog2(MAX_SITES+1)-1:0] n_eff,
  output logic                           q_wr_valid,
  input  logic                           q_wr_ready,
  output schr_pkg::qentry_t              q_wr_data
);
  import schr_pkg::*;

  localparam int SITE_W = $clog2(MAX_SITES);
  localparam int CNT_W  = $clog2(MAX_SITES + 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RANK = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  qentry_t              item_r, item_nxt;
  logic [SITE_W-1:0]    p_r, p_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [STATE_W-1:0]   mask16;
  logic [MAX_SITES-1:0] st_w;
  logic                 bit_p;
  logic [CNT_W-1:0]     k_inc;

  assign in_ch.ready = (state_r == F_IDLE);
  assign q_wr_valid  = (state_r == F_PUSH);
  assign q_wr_data   = item_r;

  // keep only the sites in use
  always_comb begin
    for (int i = 0; i < STATE_W; i++) begin
      mask16[i] = (i < int'(n_eff));
    end
  end

  assign st_w  = MAX_SITES'(item_r.basis_state);
  assign bit_p = st_w[p_r];
  assign k_inc = k_r + CNT_W'(bit_p);

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          item_nxt.func        = in_ch.func;
          item_nxt.site_index  = in_ch.site_index;
          item_nxt.field_value = in_ch.field_value;
          item_nxt.basis_state = in_ch.basis_state & mask16;
          item_nxt.col         = '0;
          p_nxt                = '0;
          k_nxt                = '0;
          state_nxt            = (in_ch.func == FUNC_STATE) ? F_RANK : F_PUSH;
        end
      end
      F_RANK: begin
        // k-th up spin at site p adds C(p,k)
        k_nxt = k_inc;
        if (bit_p) begin
          item_nxt.col = item_r.col + binom_mod(BINOM_P_W'(p_r), BINOM_K_W'(k_inc));
        end
        if (CNT_W'(p_r) + CNT_W'(1) == n_eff) begin
          state_nxt = F_PUSH;
        end else begin
          p_nxt = p_r + SITE_W'(1);
        end
      end
      F_PUSH: begin
        if (q_wr_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      p_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

/* sv/schr_back.sv */
// back end: field table, site walk for flips and the diagonal, output register
module schr_back #(
  parameter int MAX_SITES = schr_pkg::MAX_SITES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(MAX_SITES+1)-1:0] n_eff,
  input  logic [schr_pkg::FIELD_W-1:0]   hop,
  input  logic                           q_rd_valid,
  output logic                           q_rd_ready,
  input  schr_pkg::qentry_t              q_rd_data,
  schr_out_if.source                     out_ch
);
  import schr_pkg::*;

  localparam int SITE_W = $clog2(MAX_SITES);
  localparam int CNT_W  = $clog2(MAX_SITES + 1);

  logic [FIELD_W-1:0]   site_field_r [MAX_SITES];
  logic                 busy_r, busy_nxt;
  logic                 diag_ph_r, diag_ph_nxt;
  qentry_t              cur_r, cur_nxt;
  logic [SITE_W-1:0]    j_r, j_nxt;
  logic [CNT_W-1:0]     cb_r, cb_nxt;
  logic [VAL_W-1:0]     diag_r, diag_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     row_r, row_nxt;
  logic [IDX_W-1:0]     col_r, col_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic                 last_r, last_nxt;

  logic                 adv;
  logic                 load_we;
  logic [MAX_SITES-1:0] st_w;
  logic [SITE_W-1:0]    jm1;
  logic                 up, prev;
  logic [VAL_W-1:0]     f32, hop32, d_site;
  logic [IDX_W-1:0]     dlt;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_index   = row_r;
  assign out_ch.col_index   = col_r;
  assign out_ch.entry_value = val_r;
  assign out_ch.last        = last_r;

  assign q_rd_ready = !busy_r;
  assign adv        = !out_valid_r || out_ch.ready;
  assign load_we    = !busy_r && q_rd_valid && (q_rd_data.func == FUNC_LOAD) &&
                      (int'(q_rd_data.site_index) < MAX_SITES);

  assign st_w  = MAX_SITES'(cur_r.basis_state);
  assign jm1   = j_r - SITE_W'(1);
  assign up    = st_w[j_r];
  assign prev  = st_w[jm1];
  assign f32   = {{(VAL_W-FIELD_W){site_field_r[j_r][FIELD_W-1]}}, site_field_r[j_r]};
  assign hop32 = {{(VAL_W-FIELD_W){hop[FIELD_W-1]}}, hop};
  // moving the pair's up spin one site shifts the rank by C(j-1, ones below the pair)
  assign dlt   = binom_mod(BINOM_P_W'(jm1), BINOM_K_W'(cb_r));

  always_comb begin
    d_site = diag_r + (up ? f32 : -f32);
    if (j_r != '0) begin
      d_site = d_site + ((up == prev) ? ONE_Q16 : -ONE_Q16);
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    diag_ph_nxt   = diag_ph_r;
    cur_nxt       = cur_r;
    j_nxt         = j_r;
    cb_nxt        = cb_r;
    diag_nxt      = diag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    if (!busy_r) begin
      if (q_rd_valid && (q_rd_data.func == FUNC_STATE)) begin
        busy_nxt    = 1'b1;
        diag_ph_nxt = 1'b0;
        cur_nxt     = q_rd_data;
        j_nxt       = '0;
        cb_nxt      = '0;
        diag_nxt    = '0;
      end
    end else if (adv) begin
      if (diag_ph_r) begin
        out_valid_nxt = 1'b1;
        row_nxt       = cur_r.col;
        col_nxt       = cur_r.col;
        val_nxt       = diag_r;
        last_nxt      = 1'b1;
        busy_nxt      = 1'b0;
      end else begin
        diag_nxt = d_site;
        if (j_r != '0) begin
          cb_nxt = cb_r + CNT_W'(prev);
          if (up != prev) begin
            out_valid_nxt = 1'b1;
            row_nxt       = prev ? cur_r.col + dlt : cur_r.col - dlt;
            col_nxt       = cur_r.col;
            val_nxt       = hop32;
            last_nxt      = 1'b0;
          end
        end
        if (CNT_W'(j_r) + CNT_W'(1) == n_eff) begin
          diag_ph_nxt = 1'b1;
        end else begin
          j_nxt = j_r + SITE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      diag_ph_r   <= 1'b0;
      j_r         <= '0;
      cb_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_SITES; i++) begin
        site_field_r[i] <= '0;
      end
    end else begin
      busy_r      <= busy_nxt;
      diag_ph_r   <= diag_ph_nxt;
      j_r         <= j_nxt;
      cb_r        <= cb_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_we) begin
        site_field_r[SITE_W'(q_rd_data.site_index)] <= q_rd_data.field_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    diag_r <= diag_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

endmodule

/* sv/spin_chain_hamiltonian_row.sv */
// top level of the spin chain hamiltonian column generator
//
// in_ch takes words: func 0 loads site_field[site_index], func 1 gives a basis
// state whose matrix column is produced. out_ch gives one word per adjacent
// antiparallel pair (row = flipped state's sector rank, value hop_amplitude),
// pairs in ascending site order, then the diagonal word with last set.
// cfg_ch writes num_sites (index 0) and hop_amplitude (index 1); it is always
// ready and must only be used while the block is idle.
// flow: the front ranks one site per cycle and keeps in_ch not ready until
// the ranked state or the load word has been pushed into the queue. the back
// pops a state, walks one site per cycle while the output register can
// advance, then emits the diagonal; the front can rank the next state while
// the back walks the previous one.
// a two-word queue parts front and back, and the output register lets the
// back keep working while out_ch is free; when the receiver stalls the back
// holds its word and the queue and then in_ch fill up.
// reset (rst_n low, synchronous) empties the queue and output, clears the
// field table and restores num_sites 16 and hop_amplitude 2.0.
module spin_chain_hamiltonian_row #(
  parameter int MAX_SITES = schr_pkg::MAX_SITES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  schr_in_if.sink    in_ch,
  schr_out_if.source out_ch,
  schr_cfg_if.sink   cfg_ch
);
  import schr_pkg::*;

  localparam int CNT_W = $clog2(MAX_SITES + 1);

  // configuration registers
  logic [NSITE_W-1:0] num_sites_r;
  logic [FIELD_W-1:0] hop_r;
  logic [CNT_W-1:0]   n_eff;

  // front to back queue
  logic    fq_wr_valid, fq_wr_ready;
  qentry_t fq_wr_data;
  logic    bq_rd_valid, bq_rd_ready;
  qentry_t bq_rd_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sites_r <= NUM_SITES_RST;
      hop_r       <= HOP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_NUM_SITES: num_sites_r <= cfg_ch.data[NSITE_W-1:0];
        REG_HOP:       hop_r       <= cfg_ch.data;
        default:       ;
      endcase
    end
  end

  // zero sites runs as one, too many saturates
  always_comb begin
    priority if (num_sites_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(num_sites_r) > MAX_SITES) begin
      n_eff = CNT_W'(MAX_SITES);
    end else begin
      n_eff = CNT_W'(num_sites_r);
    end
  end

  schr_front #(
    .MAX_SITES (MAX_SITES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .n_eff      (n_eff),
    .q_wr_valid (fq_wr_valid),
    .q_wr_ready (fq_wr_ready),
    .q_wr_data  (fq_wr_data)
  );

  schr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_wr_valid),
    .wr_ready (fq_wr_ready),
    .wr_data  (fq_wr_data),
    .rd_valid (bq_rd_valid),
    .rd_ready (bq_rd_ready),
    .rd_data  (bq_rd_data)
  );

  schr_back #(
    .MAX_SITES (MAX_SITES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_eff      (n_eff),
    .hop        (hop_r),
    .q_rd_valid (bq_rd_valid),
    .q_rd_ready (bq_rd_ready),
    .q_rd_data  (bq_rd_data),
    .out_ch     (out_ch)
  );

endmodule

/* sv/schr_checker.sv */
// port level checks on the result channel, bound to the top level
module schr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [schr_pkg::IDX_W-1:0]    out_row_index,
  input logic [schr_pkg::IDX_W-1:0]    out_col_index,
  input logic [schr_pkg::VAL_W-1:0]    out_entry_value,
  input logic                          out_last
);
  import schr_pkg::*;

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) &&
    $stable(out_col_index) && $stable(out_entry_value) && $stable(out_last))
    else $error("stalled result word changed");

  // the diagonal sits on the column itself
  a_diag_on_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row_index == out_col_index)
    else $error("diagonal word off the diagonal");

  // a run keeps its column until the word marked last
  a_col_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !out_valid || out_col_index == $past(out_col_index))
    else $error("column changed inside a run");

endmodule

bind spin_chain_hamiltonian_row schr_checker u_schr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_row_index   (out_ch.row_index),
  .out_col_index   (out_ch.col_index),
  .out_entry_value (out_ch.entry_value),
  .out_last        (out_ch.last)
);

/* test/tb_top.sv */
// testbench for the spin chain hamiltonian column generator: directed and random checks
module tb_top;
  import schr_pkg::*;

  // quiet cycles after the last result before a register write or the end
  localparam int DRAIN_CYCLES = 50;
  // cycles with no word moving on any channel before the run is abandoned
  localparam int STALL_LIMIT  = 2000;
  // long receiver hold-off for the back-pressure test
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [VAL_W-1:0] entry_value;
    logic             last;
  } matrix_entry_t;

  logic clk = 1'b0;
  logic rst_n;

  schr_in_if  in_ch ();
  schr_out_if out_ch ();
  schr_cfg_if cfg_ch ();

  spin_chain_hamiltonian_row DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // own copy of the registers and the field table
  logic [NSITE_W-1:0]        num_sites_q;
  logic signed [FIELD_W-1:0] hop_q;
  logic signed [FIELD_W-1:0] field_q [MAX_SITES_DEF];

  // matrix entries still to come, oldest first
  matrix_entry_t pending_entries [$];
  matrix_entry_t want_entry;

  int err_count   = 0;
  int tx_gap_max  = 7;
  int rx_gap_max  = 7;
  int rx_wait     = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  // binomial coefficient, zero when k exceeds n
  function automatic int unsigned choose(input int n, input int k);
    int unsigned r;
    r = 1;
    if (k > n) begin
      return 0;
    end
    for (int i = 0; i < k; i++) begin
      r = r * (n - i) / (i + 1);
    end
    return r;
  endfunction

  // colex rank within the sector of equal up-spin count
  function automatic logic [IDX_W-1:0] sector_rank(input logic [STATE_W-1:0] s, input int n);
    int          k;
    int unsigned r;
    k = 0;
    r = 0;
    for (int p = 0; p < n; p++) begin
      if (s[p]) begin
        k++;
        r += choose(p, k);
      end
    end
    return r[IDX_W-1:0];
  endfunction

  // works out the whole column of one basis state and queues its entries
  task automatic predict_column(input logic [STATE_W-1:0] raw);
    int                      n;
    logic [STATE_W-1:0]      st;
    logic [STATE_W-1:0]      flipped;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] diag;
    logic signed [VAL_W-1:0] f;
    logic signed [VAL_W-1:0] hop_ext;
    logic                    up;
    logic                    prev;
    matrix_entry_t           e;
    n = int'(num_sites_q);
    // zero sites counts as one, too many saturates
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_SITES_DEF) begin
      n = MAX_SITES_DEF;
    end
    st = raw & STATE_W'((32'd1 << n) - 1);
    col = sector_rank(st, n);
    hop_ext = hop_q;
    diag = '0;
    for (int j = 0; j < n; j++) begin
      up = st[j];
      f = field_q[j];
      diag = up ? diag + f : diag - f;
      if (j > 0) begin
        prev = st[j-1];
        if (up == prev) begin
          diag = diag + ONE_Q16;
        end else begin
          // antiparallel pair: hop to the state with both spins flipped
          flipped = st ^ (STATE_W'(3) << (j - 1));
          e.row_index   = sector_rank(flipped, n);
          e.col_index   = col;
          e.entry_value = hop_ext;
          e.last        = 1'b0;
          pending_entries.push_back(e);
          diag = diag - ONE_Q16;
        end
      end
    end
    e.row_index   = col;
    e.col_index   = col;
    e.entry_value = diag;
    e.last        = 1'b1;
    pending_entries.push_back(e);
  endtask

  // offers one input word after a random gap and waits for it to be taken
  task automatic send_word(input logic func, input logic [SIDX_W-1:0] site,
                           input logic [FIELD_W-1:0] value,
                           input logic [STATE_W-1:0] state);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func;
    in_ch.site_index  <= site;
    in_ch.field_value <= value;
    in_ch.basis_state <= state;
    do @(posedge clk); while (!in_ch.ready);
    if (func == FUNC_LOAD) begin
      field_q[site] = value;
    end else begin
      predict_column(state);
    end
  endtask

  task automatic load_field(input logic [SIDX_W-1:0] site, input logic [FIELD_W-1:0] value);
    send_word(FUNC_LOAD, site, value, STATE_W'($urandom));
  endtask

  task automatic send_state(input logic [STATE_W-1:0] state);
    send_word(FUNC_STATE, SIDX_W'($urandom), FIELD_W'($urandom), state);
  endtask

  // stop offering, let every expected word arrive, then wait out any load still in flight
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_NUM_SITES) begin
      num_sites_q = data[NSITE_W-1:0];
    end else begin
      hop_q = data;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // reset values, all-down, all-up and both alternating patterns
  task automatic test_default_column();
    send_state(16'h0000);
    send_state(16'hFFFF);
    send_state(16'h5555);
    send_state(16'hAAAA);
  endtask

  // most negative and most positive fields at the chain ends
  task automatic test_field_extremes();
    load_field(4'd0, 24'h800000);
    load_field(4'd15, 24'h7FFFFF);
    load_field(4'd7, 24'h123456);
    send_state(16'h8001);
    send_state(16'h7FFE);
  endtask

  // single site, zero sites, saturated count and a two-site chain
  task automatic test_site_count();
    settle();
    write_reg(REG_NUM_SITES, FIELD_W'(1));
    send_state(16'h0001);
    send_state(16'hFFFE);
    settle();
    write_reg(REG_NUM_SITES, FIELD_W'(0));
    send_state(16'h0001);
    settle();
    write_reg(REG_NUM_SITES, FIELD_W'(31));
    send_state(16'hFFFF);
    settle();
    write_reg(REG_NUM_SITES, FIELD_W'(2));
    send_state(16'h0001);
  endtask

  // hop amplitude at both ends of its range
  task automatic test_hop_extremes();
    settle();
    write_reg(REG_NUM_SITES, FIELD_W'(16));
    write_reg(REG_HOP, 24'h800000);
    send_state(16'h5555);
    settle();
    write_reg(REG_HOP, 24'h7FFFFF);
    send_state(16'h0F0F);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    settle();
    write_reg(REG_HOP, FIELD_W'($urandom));
    tx_gap_max = 0;
    rx_gap_max = 0;
    hold_left  = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_state((i % 2 == 0) ? 16'h5555 : STATE_W'($urandom));
    end
    tx_gap_max = 7;
    rx_gap_max = 7;
  endtask

  // one random word: loads, many-flip patterns, sparse states and noise
  task automatic random_word();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      load_field(SIDX_W'($urandom), FIELD_W'($urandom));
    end else if (sel < 40) begin
      send_state(($urandom_range(0, 1) ? 16'h5555 : 16'hAAAA) ^
                 (STATE_W'(1) << $urandom_range(0, 15)));
    end else if (sel < 50) begin
      send_state((STATE_W'(1) << $urandom_range(0, 15)) |
                 (STATE_W'(1) << $urandom_range(0, 15)));
    end else begin
      send_state(STATE_W'($urandom));
    end
  endtask

  // phases over several register settings, some with no idling at all
  task automatic test_random_columns();
    int          n;
    logic [23:0] upper;
    for (int phase = 0; phase < 9; phase++) begin
      settle();
      case (phase)
        0: n = 16;
        1: n = 1;
        2: n = 0;
        3: n = 31;
        default: n = $urandom_range(2, 16);
      endcase
      // junk above the count field is dropped by the block
      upper = FIELD_W'($urandom) & 24'hFFFFE0;
      write_reg(REG_NUM_SITES, upper | FIELD_W'(n));
      write_reg(REG_HOP, FIELD_W'($urandom));
      tx_gap_max = (phase % 3 == 1) ? 0 : 7;
      rx_gap_max = (phase % 3 == 1) ? 0 : 7;
      repeat (40) random_word();
    end
    tx_gap_max = 7;
    rx_gap_max = 7;
  endtask

  // receiver: long hold first, then the per-word random gap
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (rx_wait > 0) begin
      out_ch.ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_wait = $urandom_range(0, rx_gap_max);
      if (pending_entries.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word expected none actual row %0d col %0d value %0d last %0d",
                 $time, out_ch.row_index, out_ch.col_index, $signed(out_ch.entry_value),
                 out_ch.last);
      end else begin
        want_entry = pending_entries.pop_front();
        if (out_ch.row_index !== want_entry.row_index) begin
          err_count++;
          $display("%0t: row_index expected %0d actual %0d",
                   $time, want_entry.row_index, out_ch.row_index);
        end
        if (out_ch.col_index !== want_entry.col_index) begin
          err_count++;
          $display("%0t: col_index expected %0d actual %0d",
                   $time, want_entry.col_index, out_ch.col_index);
        end
        if (out_ch.entry_value !== want_entry.entry_value) begin
          err_count++;
          $display("%0t: entry_value expected %0d actual %0d",
                   $time, $signed(want_entry.entry_value), $signed(out_ch.entry_value));
        end
        if (out_ch.last !== want_entry.last) begin
          err_count++;
          $display("%0t: last expected %0d actual %0d",
                   $time, want_entry.last, out_ch.last);
        end
      end
    end
  end

  // watchdog on cycles where no word moves anywhere
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_LOAD;
    in_ch.site_index  = '0;
    in_ch.field_value = '0;
    in_ch.basis_state = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_NUM_SITES;
    cfg_ch.data       = '0;
    out_ch.ready      = 1'b0;
    num_sites_q       = NUM_SITES_RST;
    hop_q             = HOP_RST;
    foreach (field_q[i]) begin
      field_q[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_column();
    test_field_extremes();
    test_site_count();
    test_hop_extremes();
    test_backpressure();
    test_random_columns();
    settle();

    if (err_count == 0 && pending_entries.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/schr_pkg.sv
sv/schr_if.sv
sv/schr_queue.sv
sv/schr_front.sv
sv/schr_back.sv
sv/spin_chain_hamiltonian_row.sv
sv/schr_checker.sv
test/tb_top.sv
